### design/mtce_pkg.sv
// Shared types, constants and the log-table entry function for the cross-entropy block.
`timescale 1ns / 1ps

package mtce_pkg;

    localparam int unsigned PROB_W  = 16;
    localparam int unsigned LOSS_W  = 20;
    localparam int unsigned COUNT_W = 17;
    localparam int unsigned SUM_W   = 37;
    localparam int unsigned POS_W   = 15;
    localparam int unsigned REG_W   = 16;
    localparam int unsigned EPS_W   = 8;

    localparam logic [15:0]     LN2_Q16  = 16'd45426;
    localparam logic [63:0]     LN2_Q32  = 64'd2977044472;
    localparam logic [LOSS_W-1:0] LOSS_MAX = 20'hFFFFF;

    typedef enum logic [0:0] {
        REG_VOCAB   = 1'b0,
        REG_EPSILON = 1'b1
    } cfg_reg_t;

    typedef struct packed {
        logic [15:0] prob;
        logic [15:0] target_class;
        logic        batch_end;
    } in_beat_t;

    typedef struct packed {
        logic [19:0] mean_loss;
        logic [16:0] scored_tokens;
        logic [16:0] hit_tokens;
    } out_beat_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_status_t;

    // ln(y0 / 2^30) in Q0.16 by bit-serial log2, evaluated at elaboration only.
    function automatic logic [15:0] ln_from_y(input logic [63:0] y0);
        logic [63:0] y;
        logic [63:0] lg;
        logic [63:0] prod;
        y  = y0;
        lg = 64'd0;
        for (int b = 29; b >= 0; b--)
        begin
            y = (y * y) >> 30;
            if (y >= (64'd1 << 31))
            begin
                y = y >> 1;
                lg = lg | (64'd1 << b);
            end
        end
        prod = (lg * LN2_Q32 + (64'd1 << 45)) >> 46;
        return prod[15:0];
    endfunction

endpackage

### design/masked_token_cross_entropy.sv
// Top level of the masked token cross-entropy and accuracy block.
//
//   Channel   Signals                            Direction  Payload
//   input     in_valid / in_ready / in_data      in         prob, target_class, batch_end
//   output    out_valid / out_ready / out_data   out        mean_loss, scored_tokens, hit_tokens
//   config    cfg_we / cfg_index / cfg_data      in         vocab size, epsilon
//
// An element that neither completes a scored row nor ends a batch leaves in_ready high.
// A completed row with a valid target enters the normalizing shifter, which moves
// prob + epsilon left one bit a cycle until its top bit is set; the table read and the
// accumulate then happen together. A batch end starts the restoring divider on its 37
// quotient bits; on its done flag the output register is loaded once the output is free.
// Reset clears all control state and accumulators; in_ready is low while an item is at work
// and while a finished result still waits on a stalled output.
`timescale 1ns / 1ps

module masked_token_cross_entropy
    import mtce_pkg::*;
#(
    parameter int unsigned VOCAB_MAX       = 32768,
    parameter int unsigned MAX_TOKENS      = 65536,
    parameter int unsigned LOG_TABLE_DEPTH = 256
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  in_beat_t    in_data,
    output logic        out_valid,
    input  logic        out_ready,
    output out_beat_t   out_data,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [15:0] cfg_data
);

    localparam int unsigned IDX_W  = $clog2(LOG_TABLE_DEPTH);
    localparam int unsigned CAP_I  = (MAX_TOKENS < 131071) ? MAX_TOKENS : 131071;
    localparam logic [COUNT_W-1:0] COUNT_CAP = CAP_I[COUNT_W-1:0];
    localparam logic [REG_W-1:0]   VMAX      = VOCAB_MAX[REG_W-1:0];

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_NORM = 4'b0010,
        ST_DIV  = 4'b0100,
        ST_OUT  = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    logic [REG_W-1:0]   vocab_reg, vocab_next;
    logic [EPS_W-1:0]   eps_reg, eps_next;
    logic [POS_W-1:0]   pos_reg, pos_next;
    logic [PROB_W-1:0]  max_reg, max_next;
    logic [POS_W-1:0]   best_reg, best_next;
    logic [15:0]        tgt_reg, tgt_next;
    logic [PROB_W-1:0]  tprob_reg, tprob_next;
    logic [SUM_W-1:0]   sum_reg, sum_next;
    logic [COUNT_W-1:0] active_reg, active_next;
    logic [COUNT_W-1:0] correct_reg, correct_next;
    logic [16:0]        norm_reg, norm_next;
    logic [4:0]         shift_reg, shift_next;
    logic               end_reg, end_next;
    logic               go_reg, go_next;
    logic               ovalid_reg, ovalid_next;
    out_beat_t          odata_reg, odata_next;

    logic [REG_W-1:0]   vocab_eff;
    logic [REG_W-1:0]   pos_plus;
    logic               row_done;
    logic               scored;
    logic [IDX_W-1:0]   tbl_idx;
    logic [31:0]        idx_prod;
    logic [15:0]        tbl_entry;
    logic [LOSS_W-1:0]  tok_loss;
    logic [LOSS_W-1:0]  scaled;
    logic [SUM_W-1:0]   quotient;
    div_status_t        div_st;

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = ovalid_reg;
    assign out_data  = odata_reg;

    // Effective vocabulary size: clamped into 2 .. VOCAB_MAX.
    always_comb
    begin
        if (vocab_reg < 16'd2)
            vocab_eff = 16'd2;
        else if (vocab_reg > VMAX)
            vocab_eff = VMAX;
        else
            vocab_eff = vocab_reg;
    end

    // Table index from the fraction bits below the leading one.
    assign idx_prod = 32'(norm_reg[15:0]) * 32'(LOG_TABLE_DEPTH);
    assign tbl_idx  = idx_prod[16 +: IDX_W];

    mtce_log_table #(
        .DEPTH (LOG_TABLE_DEPTH)
    ) u_table (
        .idx   (tbl_idx),
        .entry (tbl_entry)
    );

    mtce_divider u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (go_reg),
        .dividend (sum_reg),
        .divisor  (active_reg),
        .quotient (quotient),
        .status   (div_st)
    );

    // Token loss once the operand is normalized; shift_reg holds 16 - k.
    always_comb
    begin
        scaled = LOSS_W'(shift_reg) * LOSS_W'(LN2_Q16);
        if (norm_reg == 17'd0)
            tok_loss = LOSS_MAX;
        else if (shift_reg == 5'd0)
            tok_loss = '0;
        else
            tok_loss = scaled - LOSS_W'(tbl_entry);
    end

    always_comb
    begin
        state_next   = state_reg;
        vocab_next   = vocab_reg;
        eps_next     = eps_reg;
        pos_next     = pos_reg;
        max_next     = max_reg;
        best_next    = best_reg;
        tgt_next     = tgt_reg;
        tprob_next   = tprob_reg;
        sum_next     = sum_reg;
        active_next  = active_reg;
        correct_next = correct_reg;
        norm_next    = norm_reg;
        shift_next   = shift_reg;
        end_next     = end_reg;
        go_next      = 1'b0;
        ovalid_next  = ovalid_reg;
        odata_next   = odata_reg;
        pos_plus     = 16'(pos_reg) + 16'd1;
        row_done     = 1'b0;
        scored       = 1'b0;

        if (ovalid_reg && out_ready)
            ovalid_next = 1'b0;

        if (cfg_we)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_VOCAB:   vocab_next = cfg_data;
                REG_EPSILON: eps_next   = cfg_data[EPS_W-1:0];
                default:     vocab_next = vocab_reg;
            endcase
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    // Row bookkeeping: argmax keeps the first maximum.
                    if (pos_reg == '0)
                    begin
                        tgt_next   = in_data.target_class;
                        max_next   = in_data.prob;
                        best_next  = '0;
                        tprob_next = '0;
                    end
                    else if (in_data.prob > max_reg)
                    begin
                        max_next  = in_data.prob;
                        best_next = pos_reg;
                    end
                    if (16'(pos_reg) == tgt_next)
                        tprob_next = in_data.prob;

                    row_done = (pos_plus >= vocab_eff);
                    if (row_done)
                    begin
                        pos_next = '0;
                        if (tgt_next != 16'd0 && tgt_next < vocab_eff
                            && active_reg < COUNT_CAP)
                        begin
                            scored      = 1'b1;
                            active_next = active_reg + 17'd1;
                            if (16'(best_next) == tgt_next)
                                correct_next = correct_reg + 17'd1;
                            norm_next  = 17'(tprob_next) + 17'(eps_reg);
                            shift_next = '0;
                        end
                    end
                    else
                    begin
                        pos_next = pos_plus[POS_W-1:0];
                    end

                    end_next = in_data.batch_end;
                    if (in_data.batch_end)
                    begin
                        pos_next   = '0;
                        max_next   = '0;
                        best_next  = '0;
                        tgt_next   = '0;
                        tprob_next = '0;
                    end

                    if (scored)
                        state_next = ST_NORM;
                    else if (in_data.batch_end)
                    begin
                        state_next = ST_DIV;
                        go_next    = 1'b1;
                    end
                end
            end
            ST_NORM:
            begin
                if (norm_reg[16] || norm_reg == 17'd0)
                begin
                    sum_next = sum_reg + SUM_W'(tok_loss);
                    if (end_reg)
                    begin
                        state_next = ST_DIV;
                        go_next    = 1'b1;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
                else
                begin
                    norm_next  = {norm_reg[15:0], 1'b0};
                    shift_next = shift_reg + 5'd1;
                end
            end
            ST_DIV:
            begin
                if (div_st.done)
                    state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (!ovalid_reg || out_ready)
                begin
                    ovalid_next = 1'b1;
                    if (active_reg == '0)
                        odata_next.mean_loss = '0;
                    else if (quotient > SUM_W'(LOSS_MAX))
                        odata_next.mean_loss = LOSS_MAX;
                    else
                        odata_next.mean_loss = quotient[LOSS_W-1:0];
                    odata_next.scored_tokens = active_reg;
                    odata_next.hit_tokens    = correct_reg;
                    sum_next     = '0;
                    active_next  = '0;
                    correct_next = '0;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            vocab_reg   <= 16'd32768;
            eps_reg     <= 8'd1;
            pos_reg     <= '0;
            max_reg     <= '0;
            best_reg    <= '0;
            tgt_reg     <= '0;
            tprob_reg   <= '0;
            sum_reg     <= '0;
            active_reg  <= '0;
            correct_reg <= '0;
            end_reg     <= 1'b0;
            go_reg      <= 1'b0;
            ovalid_reg  <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            vocab_reg   <= vocab_next;
            eps_reg     <= eps_next;
            pos_reg     <= pos_next;
            max_reg     <= max_next;
            best_reg    <= best_next;
            tgt_reg     <= tgt_next;
            tprob_reg   <= tprob_next;
            sum_reg     <= sum_next;
            active_reg  <= active_next;
            correct_reg <= correct_next;
            end_reg     <= end_next;
            go_reg      <= go_next;
            ovalid_reg  <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        norm_reg  <= norm_next;
        shift_reg <= shift_next;
        odata_reg <= odata_next;
    end

`ifndef SYNTHESIS
    a_correct_le_active: assert property (@(posedge clk) disable iff (!rst_n)
        correct_reg <= active_reg)
        else $error("correct count exceeds active count");

    a_active_capped: assert property (@(posedge clk) disable iff (!rst_n)
        active_reg <= COUNT_CAP)
        else $error("active count above its cap");

    a_result_from_out: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(ovalid_reg) |-> $past(state_reg == ST_OUT))
        else $error("result loaded outside the output state");

    a_div_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        div_st.done |-> state_reg == ST_DIV)
        else $error("divider finished outside the divide state");
`endif

endmodule

### design/mtce_log_table.sv
// Constant table of ln(1 + i/DEPTH) in Q0.16, read combinationally.
`timescale 1ns / 1ps

module mtce_log_table
    import mtce_pkg::*;
#(
    parameter int unsigned DEPTH = 256
)
(
    input  logic [$clog2(DEPTH)-1:0] idx,
    output logic [15:0]              entry
);

    logic [15:0] rom [DEPTH];

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_rom
        localparam logic [63:0] Y0 = (64'd1 << 30) + ((64'(i) << 30) / DEPTH);
        localparam logic [15:0] VAL = ln_from_y(Y0);
        assign rom[i] = VAL;
    end

    assign entry = rom[idx];

endmodule

### design/mtce_divider.sv
// Restoring divider: one quotient bit per cycle, 37-bit dividend over 17-bit divisor.
`timescale 1ns / 1ps

module mtce_divider
    import mtce_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [SUM_W-1:0]   dividend,
    input  logic [COUNT_W-1:0] divisor,
    output logic [SUM_W-1:0]   quotient,
    output div_status_t        status
);

    logic [SUM_W-1:0]   q_reg, q_next;
    logic [COUNT_W-1:0] rem_reg, rem_next;
    logic [5:0]         cnt_reg, cnt_next;
    logic               busy_reg, busy_next;
    logic               done_reg, done_next;
    logic [COUNT_W:0]   trial;
    logic [COUNT_W:0]   diff;

    always_comb
    begin
        trial     = {rem_reg, q_reg[SUM_W-1]};
        diff      = trial - {1'b0, divisor};
        q_next    = q_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            q_next    = dividend;
            rem_next  = '0;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, divisor})
            begin
                rem_next = diff[COUNT_W-1:0];
                q_next   = {q_reg[SUM_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[COUNT_W-1:0];
                q_next   = {q_reg[SUM_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 6'd1;
            if (cnt_reg == 6'(SUM_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg   <= q_next;
        rem_reg <= rem_next;
    end

    assign quotient    = q_reg;
    assign status.busy = busy_reg;
    assign status.done = done_reg;

endmodule

### test/tb_top.sv
// Self-checking testbench for the masked token cross-entropy and accuracy block.
`timescale 1ns / 1ps

module tb_top;
    import mtce_pkg::*;

    localparam int unsigned VOCAB_LIMIT = 32768;
    localparam int unsigned TOKEN_CAP   = 65536;
    localparam int unsigned TABLE_DEPTH = 256;
    // Longest quiet stretch allowed before the run is declared hung.
    localparam int unsigned HANG_LIMIT  = 20000;
    // Cycles to let pass after the last result so that a scored row still in the
    // shifter or an accumulate has surely landed before the registers change.
    localparam int unsigned SETTLE      = 60;

    // The scoreboard carries its own copy of the row and batch state. Each input
    // beat is pushed through that copy; a batch end leaves one expected summary.
    class loss_scoreboard;
        bit [15:0]   vocab_reg;
        bit [7:0]    eps_reg;
        bit [14:0]   pos;
        bit [15:0]   max_prob;
        bit [14:0]   best_idx;
        bit [15:0]   tgt;
        bit [15:0]   tgt_prob;
        bit [36:0]   loss_acc;
        bit [16:0]   active_cnt;
        bit [16:0]   correct_cnt;
        bit [15:0]   ln_table [TABLE_DEPTH];
        out_beat_t   summaries [$];
        int unsigned errors;

        function new();
            bit [63:0] y;
            bit [63:0] lg;
            bit [63:0] prod;
            // ln(1 + i/D) in Q0.16: bit-serial log2 in Q0.30, then times ln2.
            for (int i = 0; i < TABLE_DEPTH; i++)
            begin
                y  = (64'd1 << 30) + ((64'(i) << 30) / TABLE_DEPTH);
                lg = 0;
                for (int b = 29; b >= 0; b--)
                begin
                    y = (y * y) >> 30;
                    if (y >= (64'd1 << 31))
                    begin
                        y = y >> 1;
                        lg[b] = 1'b1;
                    end
                end
                prod = (lg * 64'd2977044472 + (64'd1 << 45)) >> 46;
                ln_table[i] = prod[15:0];
            end
            errors = 0;
            vocab_reg = 16'd32768;
            eps_reg = 8'd1;
            clear_batch();
        endfunction

        function void clear_batch();
            pos = 0;
            max_prob = 0;
            best_idx = 0;
            tgt = 0;
            tgt_prob = 0;
            loss_acc = 0;
            active_cnt = 0;
            correct_cnt = 0;
        endfunction

        function void write_reg(cfg_reg_t r, bit [15:0] v);
            if (r == REG_VOCAB)
                vocab_reg = v;
            else
                eps_reg = v[7:0];
        endfunction

        function int unsigned eff_vocab();
            if (vocab_reg < 2)
                return 2;
            if (vocab_reg > VOCAB_LIMIT)
                return VOCAB_LIMIT;
            return vocab_reg;
        endfunction

        // -ln(p + eps) in Q4.16 through the table, with a normalizing shift.
        function bit [19:0] neg_log(bit [15:0] p);
            bit [16:0] x;
            bit [16:0] shifted;
            int unsigned k;
            x = 17'(p) + 17'(eps_reg);
            if (x == 0)
                return LOSS_MAX;
            k = 0;
            while (k < 16 && (x >> (k + 1)) != 0)
                k++;
            if (k >= 16)
                return 0;
            shifted = x << (16 - k);
            return 20'((16 - k) * 45426) - 20'(ln_table[shifted[15:8]]);
        endfunction

        function void note_beat(in_beat_t b);
            int unsigned vocab;
            bit [36:0] mean;
            out_beat_t s;
            vocab = eff_vocab();
            if (pos == 0)
            begin
                tgt = b.target_class;
                max_prob = b.prob;
                best_idx = 0;
                tgt_prob = 0;
            end
            else if (b.prob > max_prob)
            begin
                max_prob = b.prob;
                best_idx = pos;
            end
            if (16'(pos) == tgt)
                tgt_prob = b.prob;
            if (int'(pos) + 1 >= vocab)
            begin
                // Padding, out-of-range targets and a full counter all skip the token.
                if (tgt != 0 && tgt < vocab && active_cnt < TOKEN_CAP)
                begin
                    loss_acc += 37'(neg_log(tgt_prob));
                    active_cnt++;
                    if (16'(best_idx) == tgt)
                        correct_cnt++;
                end
                pos = 0;
            end
            else
                pos = pos + 1;
            if (b.batch_end)
            begin
                mean = (active_cnt != 0) ? loss_acc / active_cnt : 0;
                s.mean_loss = (mean > LOSS_MAX) ? LOSS_MAX : mean[19:0];
                s.scored_tokens = active_cnt;
                s.hit_tokens = correct_cnt;
                summaries.push_back(s);
                clear_batch();
            end
        endfunction

        task report(string what, int unsigned got, int unsigned want);
            $display("mismatch: %s got %0d expected %0d at %0t", what, got, want, $realtime);
            errors++;
        endtask

        task check_result(out_beat_t r);
            out_beat_t e;
            if (summaries.size() == 0)
            begin
                report("unexpected summary, mean_loss", r.mean_loss, 0);
                return;
            end
            e = summaries.pop_front();
            if (r.mean_loss != e.mean_loss)
                report("mean_loss", r.mean_loss, e.mean_loss);
            if (r.scored_tokens != e.scored_tokens)
                report("scored_tokens", r.scored_tokens, e.scored_tokens);
            if (r.hit_tokens != e.hit_tokens)
                report("hit_tokens", r.hit_tokens, e.hit_tokens);
        endtask
    endclass

    logic        clk = 1'b0;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    in_beat_t    in_data;
    logic        out_valid;
    logic        out_ready;
    out_beat_t   out_data;
    logic        cfg_we;
    logic        cfg_index;
    logic [15:0] cfg_data;

    loss_scoreboard sb = new();
    int unsigned    send_idle_pct;
    int unsigned    recv_idle_pct;
    int unsigned    quiet_cycles;

    masked_token_cross_entropy #(
        .VOCAB_MAX(VOCAB_LIMIT),
        .MAX_TOKENS(TOKEN_CAP),
        .LOG_TABLE_DEPTH(TABLE_DEPTH)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .in_data(in_data),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .out_data(out_data),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always
    begin
        clk = 1'b1;
        #6;
        clk = 1'b0;
        #6;
    end

    // Both monitors sample at the rising edge, before the block updates.
    always @(posedge clk)
    begin
        if (rst_n && in_valid && in_ready)
            sb.note_beat(in_data);
        if (rst_n && out_valid && out_ready)
            sb.check_result(out_data);
    end

    // Receiver stalls are redrawn on every falling edge.
    always @(negedge clk)
    begin
        out_ready <= rst_n && ($urandom_range(99) >= recv_idle_pct);
    end

    // The hang watchdog restarts on any accepted beat on either channel.
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n)
            quiet_cycles <= 0;
        else if (quiet_cycles >= HANG_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // Presents one beat and holds it until the block takes it. A sender gap
    // drops valid only at a falling edge where no new beat is raised.
    task automatic send(logic [15:0] p, logic [15:0] t, logic e);
        in_beat_t b;
        b.prob = p;
        b.target_class = t;
        b.batch_end = e;
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data <= b;
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    // Waits for every summary to come back, then for the block to settle.
    task automatic drain();
        @(negedge clk);
        in_valid <= 1'b0;
        while (sb.summaries.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_reg(cfg_reg_t r, logic [15:0] v);
        drain();
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= r;
        cfg_data <= v;
        sb.write_reg(r, v);
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // One batch of rows with random content. Most targets are valid; some are
    // padding or out of range, and a few batches end partway through a row.
    task automatic random_batch(int unsigned vocab);
        int unsigned rows;
        int unsigned cut;
        int unsigned n;
        logic [15:0] t;
        logic [15:0] p;
        rows = $urandom_range(5);
        n = rows * vocab;
        cut = ($urandom_range(9) == 0) ? $urandom_range(vocab - 1) : 0;
        n = n + cut;
        if (n == 0)
            n = 1;
        for (int i = 0; i < n; i++)
        begin
            if (i % vocab == 0)
            begin
                case ($urandom_range(9))
                    0: t = 16'd0;
                    1: t = 16'($urandom);
                    default: t = 16'($urandom_range(vocab - 1, 1));
                endcase
            end
            else
                t = 16'($urandom);
            case ($urandom_range(7))
                0: p = 16'd0;
                1: p = 16'hFFFF;
                2: p = 16'($urandom_range(255));
                default: p = 16'($urandom);
            endcase
            send(p, t, i == n - 1);
        end
    endtask

    initial
    begin
        int unsigned vocab_pick [8];
        int unsigned v;
        vocab_pick = '{2, 3, 4, 5, 8, 16, 0, 1};
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        out_ready = 1'b0;
        cfg_we = 1'b0;
        cfg_index = REG_VOCAB;
        cfg_data = '0;
        send_idle_pct = 29;
        recv_idle_pct = 72;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed part: vocabulary of four, no epsilon.
        write_reg(REG_VOCAB, 16'd4);
        write_reg(REG_EPSILON, 16'd0);
        // Padding row, then a target whose probability is zero (saturated loss).
        send(16'd10, 16'd0, 0); send(16'd20, 16'hFFFF, 0);
        send(16'd30, 16'd0, 0); send(16'd40, 16'd0, 0);
        send(16'd0, 16'd3, 0); send(16'd9, 16'd0, 0);
        send(16'd5, 16'd0, 0); send(16'd0, 16'd0, 0);
        // Tie on the maximum: the first one wins, so target 2 is wrong here.
        send(16'd500, 16'd2, 0); send(16'd900, 16'd0, 0);
        send(16'd900, 16'd0, 0); send(16'd1, 16'd0, 0);
        // Target at or above the vocabulary is skipped.
        send(16'hFFFF, 16'd5, 0); send(16'd1, 16'd0, 0);
        send(16'd2, 16'd0, 0); send(16'd3, 16'd0, 1);
        // Epsilon pushes the argument to one or above: zero loss.
        write_reg(REG_EPSILON, 16'd255);
        send(16'd0, 16'd1, 0); send(16'hFFFF, 16'd0, 0);
        send(16'd7, 16'd0, 0); send(16'd7, 16'd0, 0);
        // Batch end partway through a row drops that row.
        send(16'd100, 16'd1, 0); send(16'd200, 16'd0, 1);
        // A batch with nothing active reports a zero mean.
        send(16'd100, 16'd0, 1);
        // A row left open while the vocabulary shrinks ends early.
        send(16'd300, 16'd2, 0); send(16'd100, 16'd0, 0);
        write_reg(REG_VOCAB, 16'd3);
        send(16'd400, 16'd0, 1);
        // Largest vocabulary, clamped from above, with an early batch end.
        write_reg(REG_VOCAB, 16'hFFFF);
        for (int i = 0; i < 12; i++)
            send(16'($urandom), 16'($urandom), i == 11);
        write_reg(REG_VOCAB, 16'd32768);
        send(16'd1, 16'd1, 1);

        // Random part in three idling regimes.
        for (int phase = 0; phase < 3; phase++)
        begin
            send_idle_pct = (phase == 0) ? 29 : (phase == 1) ? 72 : 0;
            recv_idle_pct = (phase == 0) ? 72 : (phase == 1) ? 29 : 0;
            for (int bt = 0; bt < 12; bt++)
            begin
                if (bt % 4 == 0)
                begin
                    write_reg(REG_VOCAB, 16'(vocab_pick[$urandom_range(7)]));
                    case ($urandom_range(3))
                        0: write_reg(REG_EPSILON, 16'd0);
                        1: write_reg(REG_EPSILON, 16'd255);
                        default: write_reg(REG_EPSILON, 16'($urandom_range(255)));
                    endcase
                end
                v = sb.eff_vocab();
                random_batch(v);
            end
        end

        drain();
        if (sb.errors == 0 && sb.summaries.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

### files.f
design/mtce_pkg.sv
design/mtce_log_table.sv
design/mtce_divider.sv
design/masked_token_cross_entropy.sv
test/tb_top.sv
